FILE: design/lz77c_pkg.sv
// ----------------------------------------------------------------------------
// LZ77 token stream checker package
// Transaction types, report codes and token format constants.
// ----------------------------------------------------------------------------
package lz77c_pkg;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_LIT_EXT = 3'd1,
    ERR_OFFSET  = 3'd2,
    ERR_SIZE    = 3'd3,
    ERR_TRUNC   = 3'd4
  } err_code_t;

  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] LIT_COUNT_EXT  = 2'b00;
  localparam logic [7:0] LIT_EXT_MIN    = 8'd3;
  localparam logic [8:0] LIT_EXT_BIAS   = 9'd2;
  localparam logic [3:0] MATCH_LEN_EXT  = 4'hF;
  localparam logic [8:0] MATCH_EXT_BIAS = 9'd15;
  localparam logic [9:0] MATCH_BIAS     = 10'd2;
  localparam logic [1:0] OFF_HI_EXPLICIT = 2'b11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        report_kind;
    err_code_t   error_code;
    logic [31:0] stream_position;
    logic [15:0] bad_value;
    logic [31:0] written_count;
    logic        stream_ok;
    logic        last_result;
  } out_t;

endpackage

FILE: design/lz77_token_stream_checker.sv
// A report is written into the output queue at its byte's transaction and is
// offered at the output once the reports ahead of it have been popped.
// One byte per cycle unless in_stall; the parser state advances once per byte.
// A byte that ends a stream with a token error loads two reports into the
// four-entry output queue; input stalls while the queue holds three or more.
// Reset (synchronous, active low) returns the parser, counters, queue and
// expected_size to zero. A final byte returns the parser and counters to zero.
// ----------------------------------------------------------------------------
// LZ77 token stream checker
// Parses a compressed token stream one byte at a time, reports token errors
// and gives a verdict on the decompressed size and truncation at the end of each stream.
// ----------------------------------------------------------------------------
module lz77_token_stream_checker #(
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lz77c_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lz77c_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  localparam int CW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef enum logic [2:0] {
    PH_INSTR    = 3'd0,
    PH_LITEXT   = 3'd1,
    PH_MATCHEXT = 3'd2,
    PH_LIT      = 3'd3,
    PH_OFFLO    = 3'd4,
    PH_OFFHI    = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              instr_r, instr_nxt;
  logic [8:0]              lit_r, lit_nxt;
  logic [8:0]              mlen_r, mlen_nxt;
  logic [7:0]              offlo_r, offlo_nxt;
  logic [COUNT_BITS-1:0]   bytes_r, bytes_nxt;
  logic [COUNT_BITS-1:0]   wr_r, wr_nxt;
  logic                    prob_r, prob_nxt;
  logic [31:0]             exp_r;

  lz77c_pkg::out_t         fifo_r [lz77c_pkg::FIFO_DEPTH];
  logic [lz77c_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [lz77c_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;

  logic                    in_acc, pop;
  logic [7:0]              b;
  logic                    err;
  lz77c_pkg::err_code_t    err_code;
  logic [15:0]             bad;
  logic [15:0]             off;
  logic                    off_chk;
  logic                    lc_en;
  logic [8:0]              lc_lit;
  logic [7:0]              lc_instr;
  logic [9:0]              add_amt;
  logic [CW-1:0]           exp_ext, bytes_ext, wr_ext;
  logic [COUNT_BITS-1:0]   exp_cut;
  logic                    size_bad, trunc;
  lz77c_pkg::err_code_t    vcode;
  lz77c_pkg::out_t         rep_err, rep_fin;
  logic [1:0]              push_n;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (cnt_r > (lz77c_pkg::FIFO_AW + 1)'(lz77c_pkg::FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = fifo_r[rptr_r];
  assign cfg_ready = 1'b1;
  assign b         = in_data.stream_byte;

  always_comb begin
    phase_nxt = phase_r;
    instr_nxt = instr_r;
    lit_nxt   = lit_r;
    mlen_nxt  = mlen_r;
    offlo_nxt = offlo_r;
    bytes_nxt = bytes_r + COUNT_BITS'(1);
    err       = 1'b0;
    err_code  = lz77c_pkg::ERR_NONE;
    bad       = '0;
    off       = '0;
    off_chk   = 1'b0;
    lc_en     = 1'b0;
    lc_lit    = '0;
    lc_instr  = instr_r;
    add_amt   = '0;
    unique case (phase_r)
      PH_LITEXT: begin
        if (b < lz77c_pkg::LIT_EXT_MIN) begin
          err      = 1'b1;
          err_code = lz77c_pkg::ERR_LIT_EXT;
          bad      = 16'(b);
        end
        lc_en  = 1'b1;
        lc_lit = 9'(b) + lz77c_pkg::LIT_EXT_BIAS;
      end
      PH_MATCHEXT: begin
        mlen_nxt = lz77c_pkg::MATCH_EXT_BIAS + 9'(b);
        if (lit_r != '0) begin
          phase_nxt = PH_LIT;
        end else if (mlen_nxt != '0) begin
          phase_nxt = PH_OFFLO;
        end else begin
          phase_nxt = PH_INSTR;
        end
      end
      PH_LIT: begin
        lit_nxt = lit_r - 9'd1;
        if (lit_nxt == '0) begin
          phase_nxt = (mlen_r != '0) ? PH_OFFLO : PH_INSTR;
        end
      end
      PH_OFFLO: begin
        offlo_nxt = b;
        if (instr_r[3:2] == lz77c_pkg::OFF_HI_EXPLICIT) begin
          phase_nxt = PH_OFFHI;
        end else begin
          off     = {6'd0, instr_r[3:2], b};
          off_chk = 1'b1;
        end
      end
      PH_OFFHI: begin
        off     = {b, offlo_r};
        off_chk = 1'b1;
      end
      default: begin
        instr_nxt = b;
        lc_instr  = b;
        if (b[1:0] == lz77c_pkg::LIT_COUNT_EXT) begin
          phase_nxt = PH_LITEXT;
        end else begin
          lc_en  = 1'b1;
          lc_lit = 9'(b[1:0] - 2'd1);
        end
      end
    endcase

    if (lc_en) begin
      lit_nxt = lc_lit;
      add_amt = 10'(lc_lit);
      if (lc_instr[7:4] == lz77c_pkg::MATCH_LEN_EXT) begin
        phase_nxt = PH_MATCHEXT;
      end else begin
        mlen_nxt = 9'(lc_instr[7:4]);
        if (lc_lit != '0) begin
          phase_nxt = PH_LIT;
        end else if (mlen_nxt != '0) begin
          phase_nxt = PH_OFFLO;
        end else begin
          phase_nxt = PH_INSTR;
        end
      end
    end

    bytes_ext = CW'(bytes_nxt);
    if (off_chk) begin
      if (CW'(off) > bytes_ext) begin
        err      = 1'b1;
        err_code = lz77c_pkg::ERR_OFFSET;
        bad      = off;
      end
      add_amt   = 10'(mlen_r) + lz77c_pkg::MATCH_BIAS;
      phase_nxt = PH_INSTR;
    end

    wr_nxt  = wr_r + COUNT_BITS'(add_amt);
    wr_ext  = CW'(wr_nxt);
    exp_ext = CW'(exp_r);
    exp_cut = exp_ext[COUNT_BITS-1:0];

    size_bad = (wr_nxt != exp_cut);
    trunc    = (phase_nxt != PH_INSTR);
    vcode    = lz77c_pkg::ERR_NONE;
    if (size_bad) begin
      vcode = lz77c_pkg::ERR_SIZE;
    end
    if (trunc) begin
      vcode = lz77c_pkg::ERR_TRUNC;
    end
    prob_nxt = prob_r || err || (in_data.final_byte && (size_bad || trunc));

    rep_err.report_kind     = lz77c_pkg::KIND_TOKEN;
    rep_err.error_code      = err_code;
    rep_err.stream_position = bytes_ext[31:0];
    rep_err.bad_value       = bad;
    rep_err.written_count   = wr_ext[31:0];
    rep_err.stream_ok       = 1'b0;
    rep_err.last_result     = !in_data.final_byte;

    rep_fin.report_kind     = lz77c_pkg::KIND_VERDICT;
    rep_fin.error_code      = vcode;
    rep_fin.stream_position = bytes_ext[31:0];
    rep_fin.bad_value       = '0;
    rep_fin.written_count   = wr_ext[31:0];
    rep_fin.stream_ok       = !prob_nxt;
    rep_fin.last_result     = 1'b1;

    if (in_data.final_byte) begin
      phase_nxt = PH_INSTR;
      instr_nxt = '0;
      lit_nxt   = '0;
      mlen_nxt  = '0;
      offlo_nxt = '0;
      bytes_nxt = '0;
      wr_nxt    = '0;
      prob_nxt  = 1'b0;
    end

    push_n  = in_acc ? (2'(err) + 2'(in_data.final_byte)) : 2'd0;
    cnt_nxt = cnt_r + (lz77c_pkg::FIFO_AW + 1)'(push_n)
            - (lz77c_pkg::FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INSTR;
      instr_r <= '0;
      lit_r   <= '0;
      mlen_r  <= '0;
      offlo_r <= '0;
      bytes_r <= '0;
      wr_r    <= '0;
      prob_r  <= 1'b0;
      exp_r   <= '0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exp_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        instr_r <= instr_nxt;
        lit_r   <= lit_nxt;
        mlen_r  <= mlen_nxt;
        offlo_r <= offlo_nxt;
        bytes_r <= bytes_nxt;
        wr_r    <= wr_nxt;
        prob_r  <= prob_nxt;
      end
      wptr_r <= wptr_r + lz77c_pkg::FIFO_AW'(push_n);
      if (pop) begin
        rptr_r <= rptr_r + lz77c_pkg::FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (err) begin
        fifo_r[wptr_r] <= rep_err;
        if (in_data.final_byte) begin
          fifo_r[wptr_r + lz77c_pkg::FIFO_AW'(1)] <= rep_fin;
        end
      end else if (in_data.final_byte) begin
        fifo_r[wptr_r] <= rep_fin;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (lz77c_pkg::FIFO_AW + 1)'(lz77c_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.final_byte |=> phase_r == PH_INSTR && bytes_r == '0 && !prob_r)
    else $error("stream state not cleared after final byte");

  a_token_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_kind == lz77c_pkg::KIND_TOKEN |-> !out_data.stream_ok)
    else $error("token error report marked ok");

  a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LIT |-> lit_r != '0)
    else $error("literal phase with no literals left");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
